FILE: hdl/bpts_pkg.sv
`timescale 1ns / 1ps
package bpts_pkg;

  localparam int NumPrioritiesDef = 32;
  localparam int NumSemaphoresDef = 8;

  typedef enum logic [2:0] {
    CMD_CREATE      = 3'd0,
    CMD_TICK        = 3'd1,
    CMD_DELAY       = 3'd2,
    CMD_SEM_CREATE  = 3'd3,
    CMD_SEM_RELEASE = 3'd4,
    CMD_SEM_TAKE    = 3'd5,
    CMD_TAKE_FINISH = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_GRANTED = 2'd1,
    ST_FAILED  = 2'd2,
    ST_BLOCKED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SEL
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan;
    logic select;
  } ctrl_t;

  typedef struct packed {
    logic is_tick;
    logic scan_done;
  } stat_t;

  function automatic logic [4:0] top_bit(input logic [31:0] m);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (m[i]) r = 5'(i);
    end
    return r;
  endfunction

endpackage

FILE: hdl/bpts_ctrl.sv
`timescale 1ns / 1ps
module bpts_ctrl
  import bpts_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  busy
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start) state_d = S_EXEC;
      S_EXEC: state_d = stat_i.is_tick ? S_SCAN : S_SEL;
      S_SCAN: if (stat_i.scan_done) state_d = S_SEL;
      S_SEL:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy = 1'b0;
        ctrl_o.capture = start;
      end
      S_EXEC: ctrl_o.exec = 1'b1;
      S_SCAN: ctrl_o.scan = 1'b1;
      S_SEL:  ctrl_o.select = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

FILE: hdl/bpts_dpath.sv
`timescale 1ns / 1ps
module bpts_dpath
  import bpts_pkg::*;
#(
  parameter int NUM_PRIORITIES = NumPrioritiesDef,
  parameter int NUM_SEMAPHORES = NumSemaphoresDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_t       ctrl_i,
  output stat_t       stat_o,
  input  logic [2:0]  cmd_i,
  input  logic [4:0]  task_priority_i,
  input  logic [31:0] tick_amount_i,
  input  logic [2:0]  sem_index_i,
  input  logic [7:0]  initial_count_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [4:0]  current_task_o,
  output logic        current_valid_o,
  output logic [31:0] ready_mask_o,
  output logic [31:0] tick_count_o
);

  localparam int NP = NUM_PRIORITIES;
  localparam int NS = NUM_SEMAPHORES;
  localparam int PW = (NP > 1) ? $clog2(NP) : 1;
  localparam int CW = $clog2(NP + 1);
  localparam int SW = (NS > 1) ? $clog2(NS) : 1;

  logic [2:0]  cmd_q;
  logic [4:0]  prio_q;
  logic [31:0] amt_q;
  logic [2:0]  si_q;
  logic [7:0]  init_q;

  logic [NP-1:0] ready_q, ready_d, delayed_q, delayed_d, blocked_q, blocked_d;
  logic [31:0]   tick_q, tick_d;
  logic [4:0]    run_q, run_d;
  logic          rvalid_q, rvalid_d;
  logic [1:0]    status_q, status_d;
  logic          done_q;
  logic [7:0]    count_q [NS];
  logic [NP-1:0] wait_q  [NS];
  logic [7:0]    count_d;
  logic [NP-1:0] wait_d;
  logic          sem_wr;

  logic [31:0] wake_mem [NP];
  logic        wr_en;
  logic [31:0] wr_data;
  logic [31:0] rd_data_q;
  logic [CW-1:0] addr_q;
  logic          rd_vld_q;
  logic [PW-1:0] rd_idx_q;

  logic [6:0]    si_ext;
  logic [SW-1:0] si;
  logic          sem_ok;
  logic [NP-1:0] rbit, wbit, pbit;
  logic [31:0]   diff;
  logic          wake;

  assign si_ext = {4'b0000, si_q};
  assign si     = si_ext[SW-1:0];
  assign sem_ok = si_ext < 7'(NS);
  assign rbit   = NP'(1) << run_q;
  assign pbit   = NP'(1) << prio_q;
  assign wbit   = NP'(1) << top_bit(32'(wait_q[si]));
  assign diff   = tick_q - rd_data_q;
  assign wake   = rd_vld_q && !diff[31] && delayed_q[rd_idx_q];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q  <= cmd_i;
      prio_q <= task_priority_i;
      amt_q  <= tick_amount_i;
      si_q   <= sem_index_i;
      init_q <= initial_count_i;
    end
    if (wr_en) wake_mem[run_q[PW-1:0]] <= wr_data;
    rd_data_q <= wake_mem[addr_q[PW-1:0]];
    rd_idx_q  <= addr_q[PW-1:0];
  end

  always_comb begin
    ready_d   = ready_q;
    delayed_d = delayed_q;
    blocked_d = blocked_q;
    tick_d    = tick_q;
    run_d     = run_q;
    rvalid_d  = rvalid_q;
    status_d  = status_q;
    count_d   = count_q[si];
    wait_d    = wait_q[si];
    sem_wr    = 1'b0;
    wr_en     = 1'b0;
    wr_data   = tick_q + amt_q;
    if (ctrl_i.exec) begin
      status_d = ST_DONE;
      case (cmd_e'(cmd_q))
        CMD_CREATE: begin
          if ({1'b0, prio_q} < 6'(NP)) begin
            ready_d  = ready_q | pbit;
            rvalid_d = 1'b1;
          end else begin
            status_d = ST_FAILED;
          end
        end
        CMD_TICK: tick_d = tick_q + 32'd1;
        CMD_DELAY: begin
          wr_data = tick_q + {16'h0000, amt_q[15:0]};
          if (amt_q[15:0] == 16'h0000) begin
            status_d = ST_DONE;
          end else if (!rvalid_q) begin
            status_d = ST_FAILED;
          end else begin
            wr_en     = 1'b1;
            delayed_d = delayed_q | rbit;
            ready_d   = ready_q & ~rbit;
          end
        end
        CMD_SEM_CREATE: begin
          if (!sem_ok) begin
            status_d = ST_FAILED;
          end else begin
            sem_wr  = 1'b1;
            count_d = init_q;
            wait_d  = '0;
          end
        end
        CMD_SEM_RELEASE: begin
          if (!sem_ok) begin
            status_d = ST_FAILED;
          end else if (wait_q[si] != '0) begin
            sem_wr    = 1'b1;
            wait_d    = wait_q[si] & ~wbit;
            blocked_d = blocked_q & ~wbit;
            delayed_d = delayed_q & ~wbit;
            ready_d   = ready_q | wbit;
          end else begin
            sem_wr  = 1'b1;
            count_d = count_q[si] + 8'd1;
          end
        end
        CMD_SEM_TAKE: begin
          if (!sem_ok) begin
            status_d = ST_FAILED;
          end else if (count_q[si] != 8'd0) begin
            sem_wr   = 1'b1;
            count_d  = count_q[si] - 8'd1;
            status_d = ST_GRANTED;
          end else if (amt_q == 32'd0 || !rvalid_q) begin
            status_d = ST_FAILED;
          end else begin
            sem_wr    = 1'b1;
            wait_d    = wait_q[si] | rbit;
            blocked_d = blocked_q | rbit;
            delayed_d = delayed_q | rbit;
            ready_d   = ready_q & ~rbit;
            wr_en     = 1'b1;
            status_d  = ST_BLOCKED;
          end
        end
        CMD_TAKE_FINISH: begin
          if (!sem_ok || !rvalid_q) begin
            status_d = ST_FAILED;
          end else if ((blocked_q & rbit) != '0) begin
            sem_wr    = 1'b1;
            wait_d    = wait_q[si] & ~rbit;
            blocked_d = blocked_q & ~rbit;
            status_d  = ST_FAILED;
          end else begin
            status_d = ST_GRANTED;
          end
        end
        default: status_d = ST_FAILED;
      endcase
    end
    if (ctrl_i.scan && wake) begin
      delayed_d[rd_idx_q] = 1'b0;
      ready_d[rd_idx_q]   = 1'b1;
    end
    if (ctrl_i.select && ready_q != '0) begin
      run_d = top_bit(32'(ready_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q   <= '0;
      delayed_q <= '0;
      blocked_q <= '0;
      tick_q    <= '0;
      run_q     <= '0;
      rvalid_q  <= 1'b0;
      status_q  <= ST_DONE;
      done_q    <= 1'b0;
      addr_q    <= '0;
      rd_vld_q  <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        count_q[i] <= '0;
        wait_q[i]  <= '0;
      end
    end else begin
      ready_q   <= ready_d;
      delayed_q <= delayed_d;
      blocked_q <= blocked_d;
      tick_q    <= tick_d;
      run_q     <= run_d;
      rvalid_q  <= rvalid_d;
      status_q  <= status_d;
      done_q    <= ctrl_i.select;
      if (sem_wr) begin
        count_q[si] <= count_d;
        wait_q[si]  <= wait_d;
      end
      if (ctrl_i.exec) begin
        addr_q   <= '0;
        rd_vld_q <= 1'b0;
      end else if (ctrl_i.scan) begin
        rd_vld_q <= addr_q < CW'(NP);
        if (addr_q < CW'(NP)) addr_q <= addr_q + CW'(1);
      end
    end
  end

  assign stat_o.is_tick   = cmd_q == CMD_TICK;
  assign stat_o.scan_done = (addr_q == CW'(NP)) && !rd_vld_q;

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign current_task_o  = run_q;
  assign current_valid_o = rvalid_q;
  assign ready_mask_o    = 32'(ready_q);
  assign tick_count_o    = tick_q;

endmodule

FILE: hdl/bitmap_priority_task_scheduler.sv
`timescale 1ns / 1ps
// Channel  | Ports                                                  | Handshake
// command  | cmd_i task_priority_i tick_amount_i sem_index_i         | start && !busy
//          | initial_count_i                                        |
// result   | status_o current_task_o current_valid_o ready_mask_o   | done_o, one cycle
//          | tick_count_o                                           |
// Non-tick commands pass through execute and select, then strobe done_o.
// A tick adds a scan between execute and select: the wake-time memory is swept one
// entry per cycle through its single registered read port.
// Reset clears all masks, counters and semaphores at once; no clearing pass.
// The receiver cannot stall; done_o is one cycle and start may coincide with it.
module bitmap_priority_task_scheduler
  import bpts_pkg::*;
#(
  parameter int NUM_PRIORITIES = NumPrioritiesDef,
  parameter int NUM_SEMAPHORES = NumSemaphoresDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd_i,
  input  logic [4:0]  task_priority_i,
  input  logic [31:0] tick_amount_i,
  input  logic [2:0]  sem_index_i,
  input  logic [7:0]  initial_count_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [4:0]  current_task_o,
  output logic        current_valid_o,
  output logic [31:0] ready_mask_o,
  output logic [31:0] tick_count_o
);

  ctrl_t ctrl;
  stat_t stat;

  bpts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy   (busy)
  );

  bpts_dpath #(
    .NUM_PRIORITIES (NUM_PRIORITIES),
    .NUM_SEMAPHORES (NUM_SEMAPHORES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .cmd_i           (cmd_i),
    .task_priority_i (task_priority_i),
    .tick_amount_i   (tick_amount_i),
    .sem_index_i     (sem_index_i),
    .initial_count_i (initial_count_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .current_task_o  (current_task_o),
    .current_valid_o (current_valid_o),
    .ready_mask_o    (ready_mask_o),
    .tick_count_o    (tick_count_o)
  );

endmodule

FILE: hdl/bpts_checker.sv
`timescale 1ns / 1ps
module bpts_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic current_valid_o
);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result word while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted word did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("back-to-back result words");

  a_valid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(current_valid_o)) else $error("current_valid_o dropped");

endmodule

bind bitmap_priority_task_scheduler bpts_checker u_bpts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .current_valid_o (current_valid_o)
);
